### src/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants shared by the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LenWidth    = 16;
  localparam int unsigned KindWidth   = 3;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [ByteWidth-1:0] StartByteReset   = 8'd165;
  localparam logic [LenWidth-1:0]  MaxBodyLenReset  = 16'd512;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_TYPE     = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_LEN_HI   = 3'd3,
    PH_HDR_SUM  = 3'd4,
    PH_BODY     = 3'd5,
    PH_BODY_SUM = 3'd6
  } phase_t;

  typedef enum logic [KindWidth-1:0] {
    KIND_BODY       = 3'd0,
    KIND_GOOD       = 3'd1,
    KIND_BAD_BODY   = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_TOO_LONG   = 3'd4
  } kind_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_START_BYTE   = 2'd0,
    CFG_MAX_BODY_LEN = 2'd1
  } cfg_index_t;

  typedef struct packed {
    kind_t                kind;
    logic [ByteWidth-1:0] packet_kind;
    logic [ByteWidth-1:0] body_byte;
    logic [LenWidth-1:0]  byte_offset;
    logic [LenWidth-1:0]  frame_length;
  } result_t;

endpackage

### src/checksummed_frame_receiver.sv
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Parses length-prefixed frames with additive 8-bit header and body checksums.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one link byte per request.
//   result channel (result_valid/result_ready + fields) gives one request for
//   each body byte and one verdict per frame (good, body checksum bad, header
//   checksum bad, length over limit).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes start_byte
//   (index 0) and max_body_len (index 1); cfg_ready is always high.
// Output: a result is registered as the byte that causes it is taken.
// Throughput: one byte per cycle while the skid entry is empty, set by the
//   single parse stage between the rx port and the result register.
// Stall: the result register is backed by one skid entry, so one more result
//   is taken while a result waits; rx_ready drops only when the skid entry
//   holds a result, and rises as soon as the receiver takes one.
// Reset: both registers return to their defaults (165, 512), the parser
//   hunts for the start byte and no result is pending.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rx_valid,
  output logic                                 rx_ready,
  input  logic [cfr_pkg::ByteWidth-1:0]        rx_byte,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [cfr_pkg::KindWidth-1:0]        result_kind,
  output logic [cfr_pkg::ByteWidth-1:0]        packet_kind,
  output logic [cfr_pkg::ByteWidth-1:0]        body_byte,
  output logic [cfr_pkg::LenWidth-1:0]         byte_offset,
  output logic [cfr_pkg::LenWidth-1:0]         frame_length,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfr_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [cfr_pkg::CfgDataWidth-1:0]     cfg_data
);

  logic [cfr_pkg::ByteWidth-1:0] start_byte;
  logic [cfr_pkg::LenWidth-1:0]  max_body_len;

  cfr_pkg::phase_t               phase, phase_next;
  logic [cfr_pkg::ByteWidth-1:0] kind_held, kind_held_next;
  logic [cfr_pkg::ByteWidth-1:0] length_low_held, length_low_held_next;
  logic [cfr_pkg::LenWidth-1:0]  body_length, body_length_next;
  logic [cfr_pkg::LenWidth-1:0]  bytes_seen, bytes_seen_next;
  logic [cfr_pkg::ByteWidth-1:0] running_sum, running_sum_next;

  cfr_pkg::result_t res;
  logic             res_fire;
  cfr_pkg::result_t out_q;
  cfr_pkg::result_t skid_q;
  logic             skid_valid;
  logic             rx_accept;
  logic             out_free;
  logic [cfr_pkg::LenWidth-1:0] seen_inc;

  assign cfg_ready = 1'b1;
  assign rx_ready  = !skid_valid;
  assign rx_accept = rx_valid && rx_ready;
  assign out_free  = !result_valid || result_ready;
  assign seen_inc  = bytes_seen + 16'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= cfr_pkg::StartByteReset;
      max_body_len <= cfr_pkg::MaxBodyLenReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfr_pkg::CFG_START_BYTE:   start_byte   <= cfg_data[cfr_pkg::ByteWidth-1:0];
        cfr_pkg::CFG_MAX_BODY_LEN: max_body_len <= cfg_data[cfr_pkg::LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // parse step
  always_comb begin
    phase_next           = phase;
    kind_held_next       = kind_held;
    length_low_held_next = length_low_held;
    body_length_next     = body_length;
    bytes_seen_next      = bytes_seen;
    running_sum_next     = running_sum;
    res_fire             = 1'b0;
    res.kind             = cfr_pkg::KIND_BODY;
    res.body_byte        = '0;
    res.byte_offset      = '0;
    unique case (phase)
      cfr_pkg::PH_TYPE: begin
        kind_held_next   = rx_byte;
        running_sum_next = running_sum + rx_byte;
        phase_next       = cfr_pkg::PH_LEN_LO;
      end
      cfr_pkg::PH_LEN_LO: begin
        length_low_held_next = rx_byte;
        running_sum_next     = running_sum + rx_byte;
        phase_next           = cfr_pkg::PH_LEN_HI;
      end
      cfr_pkg::PH_LEN_HI: begin
        running_sum_next = running_sum + rx_byte;
        body_length_next = {rx_byte, length_low_held};
        bytes_seen_next  = '0;
        if ({rx_byte, length_low_held} > max_body_len) begin
          phase_next = cfr_pkg::PH_HUNT;
          res_fire   = 1'b1;
          res.kind   = cfr_pkg::KIND_TOO_LONG;
        end else begin
          phase_next = cfr_pkg::PH_HDR_SUM;
        end
      end
      cfr_pkg::PH_HDR_SUM: begin
        if (running_sum != rx_byte) begin
          phase_next = cfr_pkg::PH_HUNT;
          res_fire   = 1'b1;
          res.kind   = cfr_pkg::KIND_BAD_HEADER;
        end else begin
          running_sum_next = running_sum + rx_byte;
          phase_next = (body_length != '0) ? cfr_pkg::PH_BODY : cfr_pkg::PH_BODY_SUM;
        end
      end
      cfr_pkg::PH_BODY: begin
        res_fire         = 1'b1;
        res.kind         = cfr_pkg::KIND_BODY;
        res.body_byte    = rx_byte;
        res.byte_offset  = bytes_seen;
        running_sum_next = running_sum + rx_byte;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= body_length) begin
          phase_next = cfr_pkg::PH_BODY_SUM;
        end
      end
      cfr_pkg::PH_BODY_SUM: begin
        phase_next = cfr_pkg::PH_HUNT;
        res_fire   = 1'b1;
        res.kind   = (running_sum == rx_byte) ? cfr_pkg::KIND_GOOD : cfr_pkg::KIND_BAD_BODY;
      end
      default: begin
        phase_next = cfr_pkg::PH_HUNT;
        if (rx_byte == start_byte) begin
          running_sum_next = rx_byte;
          phase_next       = cfr_pkg::PH_TYPE;
        end
      end
    endcase
    res.packet_kind  = kind_held;
    res.frame_length = body_length_next;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cfr_pkg::PH_HUNT;
      kind_held       <= '0;
      length_low_held <= '0;
      body_length     <= '0;
      bytes_seen      <= '0;
      running_sum     <= '0;
    end else if (rx_accept) begin
      phase           <= phase_next;
      kind_held       <= kind_held_next;
      length_low_held <= length_low_held_next;
      body_length     <= body_length_next;
      bytes_seen      <= bytes_seen_next;
      running_sum     <= running_sum_next;
    end
  end

  // result register and skid entry, control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= rx_accept && res_fire;
      end
    end else if (rx_accept && res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // result register and skid entry, payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (rx_accept && res_fire) begin
        out_q <= res;
      end
    end else if (rx_accept && res_fire) begin
      skid_q <= res;
    end
  end

  assign result_kind  = out_q.kind;
  assign packet_kind  = out_q.packet_kind;
  assign body_byte    = out_q.body_byte;
  assign byte_offset  = out_q.byte_offset;
  assign frame_length = out_q.frame_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds a result while the result register is empty");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != cfr_pkg::KIND_BODY) |->
      (body_byte == '0 && byte_offset == '0))
    else $error("verdict result carries body data");

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == cfr_pkg::PH_BODY) |-> (bytes_seen < body_length))
    else $error("body byte count ran past the frame length");

  a_verdict_rehunt: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && phase == cfr_pkg::PH_BODY_SUM) |=> (phase == cfr_pkg::PH_HUNT))
    else $error("parser did not return to hunting after the body checksum");

endmodule
